[hw/rtl/rtcser_pkg.sv]
// Shared types and constants for the three-wire clock chip serial master.
`timescale 1ns / 1ps
package rtcser_pkg;

	// Action codes carried on the input tuser.
	localparam logic [1:0] ACT_IDLE  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Register map.
	localparam logic [2:0] REG_PHASE_TICKS = 3'd0;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd4;

	localparam int BITS_PER_BYTE = 8;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_SETUP = 7'b0000010,
		PH_TXLO  = 7'b0000100,
		PH_TXHI  = 7'b0001000,
		PH_RXHI  = 7'b0010000,
		PH_RXLO  = 7'b0100000,
		PH_END   = 7'b1000000
	} phase_t;

	// One tick result: pin levels and status after the tick.
	typedef struct packed {
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       data_level;
		logic       data_drive;
		logic       serial_clock;
		logic       chip_enable;
	} res_t;

endpackage

[hw/rtl/three_wire_rtc_serial_master_core.sv]
// Top level: stream ports, phase length register and result register.
`timescale 1ns / 1ps
// Three-wire serial master for a clock chip, driven one tick per input transfer.
// Each slave-side transfer is one tick: tuser carries the action (idle, start
// write, start read), tdata the command byte, write byte and sampled data pin.
// Every accepted tick yields exactly one master-side transfer with the pin
// levels (chip enable, serial clock, data drive and level), busy, a one-tick
// done pulse and the received byte.
// Output: a result appears on m_tvalid the cycle after its tick is accepted.
// Throughput: one tick per cycle unless m_tready stalls; the sequencer state and
// the result register update in the same edge, so a tick can enter every cycle.
// Stall: s_tready follows m_tready while a result is waiting; the result
// register holds until taken, and a new tick is taken in the cycle it drains.
// Reset: the sequencer returns to idle, the result register empties and the
// phase length register returns to 4 ticks per half clock phase.
// APB: phase_ticks at byte address 0; a value of 0 acts as 1.
module three_wire_rtc_serial_master_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command_byte[7:0], write_byte[15:8], data_pin_in[16]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // chip_enable[0], serial_clock[1], data_drive[2],
	                               // data_level[3], busy_res[4], done_res[5],
	                               // read_byte[13:6]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rtcser_pkg::*;

	logic        s_xfer;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic [7:0]  phase_ticks_q;
	logic        reg_sel;
	res_t        res;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_PHASE_TICKS[2]);
	assign prdata  = reg_sel ? {24'd0, phase_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			phase_ticks_q <= pwdata[7:0];
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_xfer   = s_tvalid && s_tready;

	rtcser_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s_xfer),
		.action       (s_tuser),
		.command_byte (s_tdata[7:0]),
		.write_byte   (s_tdata[15:8]),
		.data_pin_in  (s_tdata[16]),
		.phase_ticks  (phase_ticks_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// payload: load on each accepted tick, hold while stalled
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			m_tdata_q <= {2'b00, res.read_byte, res.done_res, res.busy_res,
			              res.data_level, res.data_drive, res.serial_clock,
			              res.chip_enable};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hw/rtl/rtcser_seq.sv]
// Bus phase sequencer: advances one tick per transfer and forms the tick result.
`timescale 1ns / 1ps
module rtcser_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [1:0]         action,
	input  logic [7:0]         command_byte,
	input  logic [7:0]         write_byte,
	input  logic               data_pin_in,
	input  logic [7:0]         phase_ticks,
	output rtcser_pkg::res_t   res
);
	import rtcser_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  bit_count_q, bit_count_n;
	logic        byte_index_q, byte_index_n;
	logic        is_read_q, is_read_n;
	logic [15:0] tx_shift_q, tx_shift_n;
	logic [7:0]  rx_shift_q, rx_shift_n;
	logic [7:0]  tick_count_q, tick_count_n;

	logic [7:0]  len;
	logic [8:0]  tick_inc;
	logic        adv;
	logic        done;
	logic [3:0]  bc_inc;

	assign len      = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
	assign tick_inc = {1'b0, tick_count_q} + 9'd1;
	assign adv      = (phase_q != PH_IDLE) && (tick_inc >= {1'b0, len});
	assign bc_inc   = bit_count_q + 4'd1;

	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		byte_index_n = byte_index_q;
		is_read_n    = is_read_q;
		tx_shift_n   = tx_shift_q;
		rx_shift_n   = rx_shift_q;
		tick_count_n = tick_count_q;
		done         = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (action == ACT_WRITE || action == ACT_READ) begin
				is_read_n    = (action == ACT_READ);
				tx_shift_n   = (action == ACT_READ) ? {8'd0, command_byte}
				                                    : {write_byte, command_byte};
				bit_count_n  = 4'd0;
				byte_index_n = 1'b0;
				tick_count_n = 8'd0;
				phase_n      = PH_SETUP;
			end
		end else if (!adv) begin
			tick_count_n = tick_inc[7:0];
		end else begin
			tick_count_n = 8'd0;
			unique case (phase_q)
				PH_SETUP: phase_n = PH_TXLO;
				PH_TXLO:  phase_n = PH_TXHI;
				PH_TXHI: begin
					tx_shift_n = {1'b0, tx_shift_q[15:1]};
					if (bc_inc < 4'(BITS_PER_BYTE)) begin
						bit_count_n = bc_inc;
						phase_n     = PH_TXLO;
					end else begin
						bit_count_n = 4'd0;
						if (!byte_index_q) begin
							byte_index_n = 1'b1;
							phase_n      = is_read_q ? PH_RXHI : PH_TXLO;
						end else begin
							phase_n = PH_END;
						end
					end
				end
				PH_RXHI:  phase_n = PH_RXLO;
				PH_RXLO: begin
					// sample at the end of the low half, fill from the top
					rx_shift_n = {data_pin_in, rx_shift_q[7:1]};
					if (bc_inc < 4'(BITS_PER_BYTE)) begin
						bit_count_n = bc_inc;
						phase_n     = PH_RXHI;
					end else begin
						bit_count_n = 4'd0;
						phase_n     = PH_END;
					end
				end
				PH_END: begin
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
				default:  phase_n = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		res              = '0;
		res.busy_res     = (phase_n != PH_IDLE);
		res.done_res     = done;
		res.read_byte    = rx_shift_n;
		unique case (phase_n)
			PH_SETUP: res.chip_enable = 1'b1;
			PH_TXLO: begin
				res.chip_enable = 1'b1;
				res.data_drive  = 1'b1;
				res.data_level  = tx_shift_n[0];
			end
			PH_TXHI: begin
				res.chip_enable  = 1'b1;
				res.serial_clock = 1'b1;
				res.data_drive   = 1'b1;
				res.data_level   = tx_shift_n[0];
			end
			PH_RXHI: begin
				res.chip_enable  = 1'b1;
				res.serial_clock = 1'b1;
			end
			PH_RXLO:  res.chip_enable = 1'b1;
			default:  res.chip_enable = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= 4'd0;
			byte_index_q <= 1'b0;
			is_read_q    <= 1'b0;
			tx_shift_q   <= 16'd0;
			rx_shift_q   <= 8'd0;
			tick_count_q <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_n;
			bit_count_q  <= bit_count_n;
			byte_index_q <= byte_index_n;
			is_read_q    <= is_read_n;
			tx_shift_q   <= tx_shift_n;
			rx_shift_q   <= rx_shift_n;
			tick_count_q <= tick_count_n;
		end
	end

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> !res.busy_res)
		else $error("done raised while still busy");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bit_count_q == 4'd0))
		else $error("bit count left nonzero in idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q < 4'(BITS_PER_BYTE))
		else $error("bit count out of range");

	a_read_no_second_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(is_read_q && byte_index_q) |-> !(phase_q == PH_TXLO || phase_q == PH_TXHI))
		else $error("read transaction shifting out a second byte");

	a_done_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> (phase_q == PH_IDLE && $past(phase_q) == PH_END))
		else $error("done pulse outside end phase");

endmodule

[tb/tb.sv]
// Self-checking testbench for the three-wire clock chip serial master core.
`timescale 1ns / 1ps
module tb;
	import rtcser_pkg::*;

	// Action 3 has no meaning and must behave as an idle tick.
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int STALL_LIMIT = 1000;

	localparam res_t LINES_IDLE = '0;
	localparam res_t LINES_SETUP = '{read_byte: 8'h00, done_res: 1'b0, busy_res: 1'b1,
		data_level: 1'b0, data_drive: 1'b0, serial_clock: 1'b0, chip_enable: 1'b1};

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] cmd;
		logic [7:0] wb;
		logic       pin;
		logic       typed;
		res_t       lines;
	} tick_row_t;

	localparam int N_ROWS = 20;
	localparam tick_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{ACT_IDLE,  8'h00, 8'h00, 1'b0, 1'b1, LINES_IDLE},
		'{ACT_SPARE, 8'h00, 8'h00, 1'b1, 1'b1, LINES_IDLE},
		'{ACT_IDLE,  8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE},
		'{ACT_SPARE, 8'hFF, 8'hFF, 1'b0, 1'b1, LINES_IDLE},
		'{ACT_READ,  8'hFF, 8'h00, 1'b0, 1'b1, LINES_SETUP},
		'{ACT_WRITE, 8'h00, 8'hFF, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_READ,  8'h5A, 8'hA5, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_SPARE, 8'hA5, 8'h5A, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_WRITE, 8'hFF, 8'hFF, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_READ,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b0, 1'b0, LINES_IDLE},
		'{ACT_IDLE,  8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // command_byte[7:0], write_byte[15:8], data_pin_in[16]
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // chip_enable[0], serial_clock[1], data_drive[2],
	                        // data_level[3], busy_res[4], done_res[5], read_byte[13:6]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	three_wire_rtc_serial_master_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sequencer mirror: state and phase length as the block should hold them.
	phase_t      seq_phase = PH_IDLE;
	logic [3:0]  bits_done = '0;
	logic        second_byte = 1'b0;
	logic        reading = 1'b0;
	logic [15:0] out_shift = '0;
	logic [7:0]  in_shift = '0;
	logic [7:0]  tick_cnt = '0;
	logic [7:0]  half_len = PHASE_TICKS_RST;

	res_t        pending_lines[$];
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	res_t        seen_lines;
	res_t        want_lines;

	// Advance the sequencer mirror by one tick and return the pin levels after it.
	function automatic res_t step_sequencer(input logic [1:0] act, input logic [7:0] cmd,
			input logic [7:0] wb, input logic pin);
		logic [8:0] len;
		logic [8:0] next_cnt;
		logic       finished;
		res_t       lines;
		len = (half_len == 8'd0) ? 9'd1 : {1'b0, half_len};
		finished = 1'b0;
		lines = '0;
		if (seq_phase == PH_IDLE) begin
			if (act == ACT_WRITE || act == ACT_READ) begin
				reading = (act == ACT_READ);
				out_shift = reading ? {8'h00, cmd} : {wb, cmd};
				bits_done = '0;
				second_byte = 1'b0;
				tick_cnt = '0;
				seq_phase = PH_SETUP;
			end
		end else begin
			next_cnt = {1'b0, tick_cnt} + 9'd1;
			if (next_cnt >= len) begin
				tick_cnt = '0;
				case (seq_phase)
					PH_SETUP: seq_phase = PH_TXLO;
					PH_TXLO: seq_phase = PH_TXHI;
					PH_TXHI: begin
						out_shift = out_shift >> 1;
						bits_done = bits_done + 4'd1;
						if (bits_done < BITS_PER_BYTE) begin
							seq_phase = PH_TXLO;
						end else begin
							bits_done = '0;
							if (!second_byte) begin
								second_byte = 1'b1;
								seq_phase = reading ? PH_RXHI : PH_TXLO;
							end else begin
								seq_phase = PH_END;
							end
						end
					end
					PH_RXHI: seq_phase = PH_RXLO;
					PH_RXLO: begin
						// shift in from the top so the first bit lands in bit 0
						in_shift = {pin, in_shift[7:1]};
						bits_done = bits_done + 4'd1;
						if (bits_done < BITS_PER_BYTE) begin
							seq_phase = PH_RXHI;
						end else begin
							bits_done = '0;
							seq_phase = PH_END;
						end
					end
					PH_END: begin
						seq_phase = PH_IDLE;
						finished = 1'b1;
					end
					default: seq_phase = PH_IDLE;
				endcase
			end else begin
				tick_cnt = next_cnt[7:0];
			end
		end
		case (seq_phase)
			PH_SETUP: lines.chip_enable = 1'b1;
			PH_TXLO: begin
				lines.chip_enable = 1'b1;
				lines.data_drive = 1'b1;
				lines.data_level = out_shift[0];
			end
			PH_TXHI: begin
				lines.chip_enable = 1'b1;
				lines.serial_clock = 1'b1;
				lines.data_drive = 1'b1;
				lines.data_level = out_shift[0];
			end
			PH_RXHI: begin
				lines.chip_enable = 1'b1;
				lines.serial_clock = 1'b1;
			end
			PH_RXLO: lines.chip_enable = 1'b1;
			default: ;
		endcase
		lines.busy_res = (seq_phase != PH_IDLE);
		lines.done_res = finished;
		lines.read_byte = in_shift;
		return lines;
	endfunction

	// Present one tick, wait for its transfer, then queue what it should produce.
	task automatic drive_tick(input logic [1:0] act, input logic [7:0] cmd,
			input logic [7:0] wb, input logic pin, input logic typed, input res_t typed_lines);
		res_t lines;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {7'b0, pin, wb, cmd};
		do @(posedge clk); while (!s_tready);
		lines = step_sequencer(act, cmd, wb, pin);
		pending_lines.push_back(typed ? typed_lines : lines);
	endtask

	task automatic check_half_len(input logic [7:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= REG_PHASE_TICKS << 2;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'h0, want}) begin
			$error("phase_ticks: expected %0h, got %0h", want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_half_len(input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_PHASE_TICKS << 2;
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		half_len = val;
		check_half_len(val);
	endtask

	// Random ticks: mostly real transactions, with some ignored starts mixed in.
	task automatic run_ticks(input int n_ticks);
		logic [1:0] act;
		for (int k = 0; k < n_ticks; k++) begin
			if (seq_phase == PH_IDLE) begin
				if ($urandom_range(7) == 0)
					act = $urandom_range(1) ? ACT_SPARE : ACT_IDLE;
				else
					act = $urandom_range(1) ? ACT_READ : ACT_WRITE;
			end else if ($urandom_range(9) == 0) begin
				act = 2'($urandom_range(3));
			end else begin
				act = ACT_IDLE;
			end
			drive_tick(act, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, LINES_IDLE);
		end
	endtask

	// Finish the transaction in flight and let every result drain.
	task automatic settle;
		while (seq_phase != PH_IDLE)
			drive_tick(ACT_IDLE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, LINES_IDLE);
		s_tvalid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
	endtask

	// Result side: random back-pressure, field checks and the stall watchdog.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_lines = res_t'(m_tdata[13:0]);
			if (pending_lines.size() == 0) begin
				$error("unexpected result transfer: %0h", m_tdata);
				mismatches++;
			end else begin
				want_lines = pending_lines.pop_front();
				if (seen_lines.chip_enable !== want_lines.chip_enable) begin
					$error("chip_enable: expected %0h, got %0h",
						want_lines.chip_enable, seen_lines.chip_enable);
					mismatches++;
				end
				if (seen_lines.serial_clock !== want_lines.serial_clock) begin
					$error("serial_clock: expected %0h, got %0h",
						want_lines.serial_clock, seen_lines.serial_clock);
					mismatches++;
				end
				if (seen_lines.data_drive !== want_lines.data_drive) begin
					$error("data_drive: expected %0h, got %0h",
						want_lines.data_drive, seen_lines.data_drive);
					mismatches++;
				end
				if (seen_lines.data_level !== want_lines.data_level) begin
					$error("data_level: expected %0h, got %0h",
						want_lines.data_level, seen_lines.data_level);
					mismatches++;
				end
				if (seen_lines.busy_res !== want_lines.busy_res) begin
					$error("busy_res: expected %0h, got %0h",
						want_lines.busy_res, seen_lines.busy_res);
					mismatches++;
				end
				if (seen_lines.done_res !== want_lines.done_res) begin
					$error("done_res: expected %0h, got %0h",
						want_lines.done_res, seen_lines.done_res);
					mismatches++;
				end
				if (seen_lines.read_byte !== want_lines.read_byte) begin
					$error("read_byte: expected %0h, got %0h",
						want_lines.read_byte, seen_lines.read_byte);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_IDLE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 37;
		sink_idle_pct = 87;
		check_half_len(PHASE_TICKS_RST);
		for (int r = 0; r < N_ROWS; r++)
			drive_tick(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].wb,
				DIRECTED_ROWS[r].pin, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].lines);
		settle();

		set_half_len(8'd1);
		run_ticks(250);
		settle();
		// zero length must behave as one tick per half phase
		set_half_len(8'd0);
		run_ticks(200);
		settle();

		src_idle_pct = 87;
		sink_idle_pct = 37;
		set_half_len(8'd2);
		run_ticks(200);
		settle();
		set_half_len(8'($urandom_range(6, 1)));
		run_ticks(200);
		settle();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		// longer phase: only a transaction or so, since each one is slow
		set_half_len(8'd8);
		run_ticks(3);
		settle();
		set_half_len(8'd3);
		run_ticks(200);
		settle();

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
